FILE: hdl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// shared constants, opcodes and control structs of the route segment mutation
// ----------------------------------------------------------------------------
`default_nettype none

package rsm_pkg;

	localparam int          MAX_CITIES_DEF = 256;
	localparam int          COUNT_W        = 9;
	localparam int          GENE_W         = 8;
	localparam logic [8:0]  CITY_RESET     = 9'd256;

	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_FLIP   = 3'd2;
	localparam logic [2:0] OP_SWAP   = 3'd3;
	localparam logic [2:0] OP_LSLIDE = 3'd4;
	localparam logic [2:0] OP_RSLIDE = 3'd5;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [GENE_W-1:0] gene_index;
		logic [GENE_W-1:0] gene_value;
		logic [GENE_W-1:0] first_index;
		logic [GENE_W-1:0] second_index;
		logic [GENE_W-1:0] new_position;
	} req_t;

	typedef struct packed {
		logic in_ready;
		logic out_valid;
		logic load;
		logic rd_gene;
		logic wr_gene;
		logic cnt_clr;
		logic copy_rd;
		logic flip;
		logic out_load;
		logic out_rd;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic is_wr;
		logic is_rd;
		logic cnt_last;
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/rsm_if.sv
// ----------------------------------------------------------------------------
// rsm_if
// valid/ready channels for mutation requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface rsm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] gene_index;
	logic [7:0] gene_value;
	logic [7:0] first_index;
	logic [7:0] second_index;
	logic [7:0] new_position;

	modport source (output valid, opcode, gene_index, gene_value, first_index,
		second_index, new_position, input ready);
	modport sink (input valid, opcode, gene_index, gene_value, first_index,
		second_index, new_position, output ready);
endinterface

interface rsm_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_value;
	logic       status;

	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/rsm_ctrl.sv
// ----------------------------------------------------------------------------
// rsm_ctrl
// sequencer for gene access and the route copy pass of a mutation
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_ctrl import rsm_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  wire   out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_RDW   = 6'b000100,
		S_COPY  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (!stat.ok) begin
					cmd.out_load = 1'b1;
					state_d      = S_OUT;
				end else if (stat.is_wr) begin
					cmd.wr_gene  = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = S_OUT;
				end else if (stat.is_rd) begin
					cmd.rd_gene = 1'b1;
					state_d     = S_RDW;
				end else begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_COPY;
				end
			end
			S_RDW: begin
				cmd.out_load = 1'b1;
				cmd.out_rd   = 1'b1;
				state_d      = S_OUT;
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.flip     = 1'b1;
				cmd.out_load = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				cmd.out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/rsm_datapath.sv
// ----------------------------------------------------------------------------
// rsm_datapath
// two-bank gene memory, request checks and permuting copy address generator
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_datapath import rsm_pkg::*; #(
	parameter int MAX_CITIES = MAX_CITIES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [COUNT_W-1:0]  cfg_wdata,
	input  req_t                req,
	input  cmd_t                cmd,
	output stat_t               stat,
	output logic [GENE_W-1:0]   read_value,
	output logic                status
);

	localparam int AW  = $clog2(MAX_CITIES);
	localparam int PW  = AW + 1;
	localparam int NW0 = $clog2(MAX_CITIES + 1);
	localparam int KW  = (NW0 > COUNT_W) ? NW0 : COUNT_W;

	logic [COUNT_W-1:0] city_count_q;
	req_t               f_q;
	logic               bank_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      j_s1;
	logic               copy_s1;
	logic [GENE_W-1:0]  rdata_q;
	logic [GENE_W-1:0]  gene_mem_q [2**(AW+1)];
	logic [GENE_W-1:0]  read_value_q;
	logic               status_q;

	logic [KW-1:0]      cc_ext, n;
	logic [GENE_W-1:0]  a8, b8;
	logic               gi_ok, ends_ok, whole, p_ok, is_mut;
	logic [PW-1:0]      a, b, p, len, jj, m, src, np;
	logic [AW:0]        raddr, waddr;
	logic               we;
	logic [GENE_W-1:0]  wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CITY_RESET;
			bank_q       <= 1'b0;
			j_q          <= '0;
			copy_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				city_count_q <= cfg_wdata;
			end
			if (cmd.flip) begin
				bank_q <= ~bank_q;
			end
			if (cmd.cnt_clr) begin
				j_q <= '0;
			end else if (cmd.copy_rd) begin
				j_q <= j_q + AW'(1);
			end
			copy_s1 <= cmd.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q <= req;
		end
		j_s1 <= j_q;
		if (cmd.out_load) begin
			status_q     <= ~stat.ok;
			read_value_q <= cmd.out_rd ? rdata_q : '0;
		end
	end

	// request checks
	always_comb begin
		cc_ext  = KW'(city_count_q);
		n       = (cc_ext > KW'(MAX_CITIES)) ? KW'(MAX_CITIES) : cc_ext;
		a8      = (f_q.first_index < f_q.second_index) ? f_q.first_index : f_q.second_index;
		b8      = (f_q.first_index < f_q.second_index) ? f_q.second_index : f_q.first_index;
		gi_ok   = KW'(f_q.gene_index) < n;
		ends_ok = (f_q.first_index != f_q.second_index) && (KW'(b8) < n);
		whole   = (a8 == '0) && (KW'(b8) == n - KW'(1));
		p_ok    = (KW'(f_q.new_position) < n)
			&& ((f_q.new_position < a8) || (f_q.new_position > b8));
		is_mut  = (f_q.opcode == OP_FLIP) || (f_q.opcode == OP_SWAP)
			|| (f_q.opcode == OP_LSLIDE) || (f_q.opcode == OP_RSLIDE);
		stat.is_wr    = (f_q.opcode == OP_WRITE);
		stat.is_rd    = (f_q.opcode == OP_READ);
		stat.ok       = ((stat.is_wr || stat.is_rd) && gi_ok)
			|| (is_mut && ends_ok && (whole || p_ok));
		stat.cnt_last = (j_q == AW'(MAX_CITIES - 1));
	end

	// source position of destination j: block move, then segment op
	always_comb begin
		a   = PW'(a8);
		b   = PW'(b8);
		p   = PW'(f_q.new_position);
		len = b - a + PW'(1);
		jj  = PW'(j_q);
		np  = PW'(n);
		if (whole || (jj >= np)) begin
			m = jj;
		end else if (p < a) begin
			priority if (jj < p) begin
				m = jj;
			end else if (jj < p + len) begin
				m = a + (jj - p);
			end else if (jj <= b) begin
				m = jj - len;
			end else begin
				m = jj;
			end
		end else begin
			priority if (jj < a) begin
				m = jj;
			end else if (jj < p - len) begin
				m = jj + len;
			end else if (jj < p) begin
				m = a + (jj - (p - len));
			end else begin
				m = jj;
			end
		end
		src = m;
		if ((jj < np) && (m >= a) && (m <= b)) begin
			unique case (f_q.opcode)
				OP_FLIP: src = a + b - m;
				OP_SWAP: src = (m == a) ? b : ((m == b) ? a : m);
				OP_LSLIDE: src = (m == b) ? a : m + PW'(1);
				OP_RSLIDE: src = (m == a) ? b : m - PW'(1);
				default: src = m;
			endcase
		end
	end

	always_comb begin
		raddr = cmd.rd_gene ? {bank_q, AW'(f_q.gene_index)} : {bank_q, src[AW-1:0]};
		we    = cmd.wr_gene | copy_s1;
		waddr = cmd.wr_gene ? {bank_q, AW'(f_q.gene_index)} : {~bank_q, j_s1};
		wdata = cmd.wr_gene ? f_q.gene_value : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			gene_mem_q[waddr] <= wdata;
		end
		rdata_q <= gene_mem_q[raddr];
	end

	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

`default_nettype wire

FILE: hdl/route_segment_mutation.sv
// ----------------------------------------------------------------------------
// route_segment_mutation
// route of city genes with flip, swap and slide segment mutations and moves
// ----------------------------------------------------------------------------
// requests arrive on req (valid/ready), one result per request leaves on rsp
// a transfer on req is taken only when the block is idle; the result stays
// on rsp until its transfer, and the next request waits for it
// steps from request transfer to result valid:
//   write or rejected request: check and any gene write in S_EVAL
//   read: gene read in S_EVAL, read value registered in S_RDW
//   mutation: S_EVAL, then one pass over a two-bank memory in S_COPY,
//   one gene read and one gene written per cycle, then bank flip in S_DRAIN
// city_count is loaded through cfg_we/cfg_wdata; the user must load it only
// while idle, the block itself does not enforce this; reset returns city_count
// to 256 and the controller to idle; gene contents are undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module route_segment_mutation import rsm_pkg::*; #(
	parameter int MAX_CITIES = MAX_CITIES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire  [COUNT_W-1:0] cfg_wdata,
	rsm_req_if.sink            req,
	rsm_rsp_if.source          rsp
);

	cmd_t  cmd;
	stat_t stat;
	req_t  req_d;

	assign req_d = '{opcode: req.opcode, gene_index: req.gene_index,
		gene_value: req.gene_value, first_index: req.first_index,
		second_index: req.second_index, new_position: req.new_position};

	rsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsm_datapath #(
		.MAX_CITIES (MAX_CITIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_d),
		.cmd        (cmd),
		.stat       (stat),
		.read_value (rsp.read_value),
		.status     (rsp.status)
	);

	assign req.ready = cmd.in_ready;
	assign rsp.valid = cmd.out_valid;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("ready while result pending");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready) else $error("second transfer accepted");
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (rsp.read_value == 8'd0))
		else $error("rejected result carries data");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the route segment mutation block
// ----------------------------------------------------------------------------
// a directed table walks gene access, every mutation, whole-route blocks and
// rejections; random phases then run at several city counts, each checked
// against a gene-level permutation model kept in this bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int RANDOM_ITEMS   = 1150;

	typedef struct {
		logic [2:0] op;
		logic [7:0] gi;
		logic [7:0] gv;
		logic [7:0] i1;
		logic [7:0] i2;
		logic [7:0] p;
		bit         pinned;
		logic [7:0] rd;
		logic       st;
	} step_t;

	typedef struct {
		bit         pinned;
		logic [7:0] rd;
		logic       st;
	} pin_t;

	typedef struct {
		logic [7:0] rd;
		logic       st;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	rsm_req_if req_ch ();
	rsm_rsp_if rsp_ch ();

	route_segment_mutation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [7:0] route_genes [256];
	bit         route_known [256];
	int         city_n;
	result_t    result_q[$];
	pin_t       pin_q[$];
	int         errors;
	int         sent_items;
	int         got_results;
	int         mutations_done;
	int         rejects_seen;
	int         idle_cycles;
	bit         calm;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// permutes genes and their written marks together
	task automatic mutate_route(input int op, input int a, input int b, input int p);
		int         src [256];
		int         moved [256];
		int         k, t, lo, hi;
		logic [7:0] g [256];
		bit         m [256];
		for (int i = 0; i < 256; i++) src[i] = i;
		case (op)
			OP_FLIP: begin
				lo = a;
				hi = b;
				while (lo < hi) begin
					t = src[lo]; src[lo] = src[hi]; src[hi] = t;
					lo++; hi--;
				end
			end
			OP_SWAP: begin
				t = src[a]; src[a] = src[b]; src[b] = t;
			end
			OP_LSLIDE: begin
				t = src[a];
				for (int i = a; i < b; i++) src[i] = src[i+1];
				src[b] = t;
			end
			default: begin
				t = src[b];
				for (int i = b; i > a; i--) src[i] = src[i-1];
				src[a] = t;
			end
		endcase
		if (!(a == 0 && b == city_n - 1)) begin
			k = 0;
			if (p < a) begin
				for (int i = 0; i < p; i++) moved[k++] = src[i];
				for (int i = a; i <= b; i++) moved[k++] = src[i];
				for (int i = p; i < a; i++) moved[k++] = src[i];
				for (int i = b + 1; i < city_n; i++) moved[k++] = src[i];
			end else begin
				for (int i = 0; i < a; i++) moved[k++] = src[i];
				for (int i = b + 1; i < p; i++) moved[k++] = src[i];
				for (int i = a; i <= b; i++) moved[k++] = src[i];
				for (int i = p; i < city_n; i++) moved[k++] = src[i];
			end
			for (int i = 0; i < city_n; i++) src[i] = moved[i];
		end
		g = route_genes;
		m = route_known;
		for (int i = 0; i < city_n; i++) begin
			route_genes[i] = g[src[i]];
			route_known[i] = m[src[i]];
		end
	endtask

	task automatic predict_route(input logic [2:0] op, input int gi, input logic [7:0] gv,
			input int i1, input int i2, input int p, output result_t res);
		int a, b;
		res.rd = 8'd0;
		res.st = 1'b1;
		a = i1 < i2 ? i1 : i2;
		b = i1 < i2 ? i2 : i1;
		if (op == OP_WRITE) begin
			if (gi < city_n) begin
				route_genes[gi] = gv;
				route_known[gi] = 1'b1;
				res.st = 1'b0;
			end
		end else if (op == OP_READ) begin
			if (gi < city_n) begin
				res.rd = route_genes[gi];
				res.st = 1'b0;
			end
		end else if (op <= OP_RSLIDE && i1 != i2 && b < city_n) begin
			if ((a == 0 && b == city_n - 1) || (p < city_n && (p < a || p > b))) begin
				mutate_route(op, a, b, p);
				res.st = 1'b0;
				mutations_done++;
			end
		end
	endtask

	always @(posedge clk) begin
		result_t res;
		pin_t    pin;
		if (req_ch.valid && req_ch.ready) begin
			predict_route(req_ch.opcode, req_ch.gene_index, req_ch.gene_value,
				req_ch.first_index, req_ch.second_index, req_ch.new_position, res);
			pin = pin_q.pop_front();
			if (pin.pinned && pin.rd !== res.rd)
				report("table read_value vs model", res.rd, pin.rd);
			if (pin.pinned && pin.st !== res.st)
				report("table status vs model", {7'd0, res.st}, {7'd0, pin.st});
			if (pin.pinned) begin
				res.rd = pin.rd;
				res.st = pin.st;
			end
			result_q = {result_q, res};
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got_results++;
			if (result_q.size() == 0) begin
				$display("unexpected result transfer at %0t", $realtime);
				errors++;
			end else begin
				res = result_q.pop_front();
				if (rsp_ch.read_value !== res.rd) report("read_value", rsp_ch.read_value, res.rd);
				if (rsp_ch.status !== res.st)
					report("status", {7'd0, rsp_ch.status}, {7'd0, res.st});
				if (res.st) rejects_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) rsp_ch.ready <= 1'b0;
		else rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("FAIL route_segment_mutation");
				$finish;
			end
		end
	end

	task automatic send_item(input step_t s);
		if (!calm && $urandom_range(99) < 24) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= s.op;
		req_ch.gene_index   <= s.gi;
		req_ch.gene_value   <= s.gv;
		req_ch.first_index  <= s.i1;
		req_ch.second_index <= s.i2;
		req_ch.new_position <= s.p;
		pin_q = {pin_q, pin_t'{s.pinned, s.rd, s.st}};
		sent_items++;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_city_count(input logic [COUNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		city_n = v > 256 ? 256 : v;
		@(posedge clk);
	endtask

	function automatic step_t random_step();
		step_t s;
		int    sel;
		s = '{op: 3'($urandom_range(7)), gi: 8'($urandom), gv: 8'($urandom),
			i1: 8'($urandom), i2: 8'($urandom), p: 8'($urandom),
			pinned: 1'b0, rd: 8'd0, st: 1'b0};
		sel = $urandom_range(99);
		if (sel < 20) begin
			s.op = OP_WRITE;
			if (city_n > 0 && $urandom_range(9) != 0) s.gi = 8'($urandom_range(city_n - 1));
		end else if (sel < 40) begin
			s.op = OP_READ;
			if (city_n > 0 && (city_n == 256 || $urandom_range(9) != 0))
				s.gi = 8'($urandom_range(city_n - 1));
			else if (city_n < 256)
				s.gi = 8'($urandom_range(255, city_n));
		end else if (sel < 85 && city_n >= 2) begin
			s.op = 3'($urandom_range(OP_RSLIDE, OP_FLIP));
			s.i1 = 8'($urandom_range(city_n - 1));
			do s.i2 = 8'($urandom_range(city_n - 1)); while (s.i2 == s.i1);
			if (!((s.i1 == 0 || s.i2 == 0) && (s.i1 == city_n - 1 || s.i2 == city_n - 1)))
				do s.p = 8'($urandom_range(city_n - 1));
				while (s.p >= (s.i1 < s.i2 ? s.i1 : s.i2) && s.p <= (s.i1 < s.i2 ? s.i2 : s.i1));
		end
		// never read a gene that holds nothing written
		if (s.op == OP_READ && s.gi < city_n && !route_known[s.gi]) s.op = OP_WRITE;
		return s;
	endfunction

	step_t table_rows [] = '{
		'{OP_WRITE, 8'd0,   8'hAA, 8'd0,  8'd0,   8'd0,   1'b1, 8'h00, 1'b0},
		'{OP_WRITE, 8'd255, 8'h55, 8'd0,  8'd0,   8'd0,   1'b1, 8'h00, 1'b0},
		'{OP_WRITE, 8'd1,   8'hFF, 8'd0,  8'd0,   8'd0,   1'b1, 8'h00, 1'b0},
		'{OP_WRITE, 8'd2,   8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'h00, 1'b0},
		'{OP_WRITE, 8'd254, 8'h81, 8'd0,  8'd0,   8'd0,   1'b1, 8'h00, 1'b0},
		'{OP_READ,  8'd0,   8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'hAA, 1'b0},
		'{OP_READ,  8'd255, 8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'h55, 1'b0},
		'{OP_FLIP,  8'd0,   8'h00, 8'd255, 8'd0,  8'd200, 1'b1, 8'h00, 1'b0},
		'{OP_READ,  8'd0,   8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'h55, 1'b0},
		'{OP_READ,  8'd255, 8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'hAA, 1'b0},
		'{OP_SWAP,  8'd0,   8'h00, 8'd0,  8'd255, 8'd7,   1'b1, 8'h00, 1'b0},
		'{OP_READ,  8'd0,   8'h00, 8'd0,  8'd0,   8'd0,   1'b1, 8'hAA, 1'b0},
		'{OP_FLIP,  8'd0,   8'h00, 8'd5,  8'd5,   8'd9,   1'b1, 8'h00, 1'b1},
		'{OP_SWAP,  8'd0,   8'h00, 8'd3,  8'd7,   8'd5,   1'b1, 8'h00, 1'b1},
		'{OP_LSLIDE, 8'd0,  8'h00, 8'd20, 8'd10,  8'd10,  1'b1, 8'h00, 1'b1},
		'{3'd6,     8'd1,   8'hFF, 8'd1,  8'd2,   8'd3,   1'b1, 8'h00, 1'b1},
		'{3'd7,     8'hFF,  8'hFF, 8'hFF, 8'hFE,  8'hFF,  1'b1, 8'h00, 1'b1},
		'{OP_LSLIDE, 8'd0,  8'h00, 8'd10, 8'd20,  8'd0,   1'b0, 8'h00, 1'b0},
		'{OP_READ,  8'd254, 8'h00, 8'd0,  8'd0,   8'd0,   1'b0, 8'h00, 1'b0},
		'{OP_RSLIDE, 8'd0,  8'h00, 8'd20, 8'd10,  8'd255, 1'b0, 8'h00, 1'b0},
		'{OP_READ,  8'd255, 8'h00, 8'd0,  8'd0,   8'd0,   1'b0, 8'h00, 1'b0},
		'{OP_RSLIDE, 8'd0,  8'h00, 8'd0,  8'd255, 8'd3,   1'b0, 8'h00, 1'b0},
		'{OP_READ,  8'd0,   8'h00, 8'd0,  8'd0,   8'd0,   1'b0, 8'h00, 1'b0}
	};

	logic [COUNT_W-1:0] phase_counts [] = '{9'd2, 9'd0, 9'd1, 9'd5, 9'd37, 9'd511,
		9'd3, 9'd300, 9'd128, 9'd256};

	initial begin
		int per_phase;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_WRITE;
		req_ch.gene_index   = '0;
		req_ch.gene_value   = '0;
		req_ch.first_index  = '0;
		req_ch.second_index = '0;
		req_ch.new_position = '0;
		rsp_ch.ready        = 1'b0;
		errors = 0; sent_items = 0; got_results = 0; mutations_done = 0;
		rejects_seen = 0; idle_cycles = 0; calm = 1'b0;
		city_n = 256;
		foreach (route_genes[i]) begin
			route_genes[i] = '0;
			route_known[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) send_item(table_rows[i]);
		drain_results();

		per_phase = RANDOM_ITEMS / phase_counts.size();
		foreach (phase_counts[ph]) begin
			set_city_count(phase_counts[ph]);
			calm = (ph == 4);
			for (int i = 0; i < per_phase; i++) send_item(random_step());
			drain_results();
		end
		calm = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items, %0d results, %0d mutations applied, %0d rejects",
			sent_items, got_results, mutations_done, rejects_seen);
		$display("city counts swept from 0 up to 511 with saturation at 256");
		if (errors == 0 && result_q.size() == 0) begin
			$display("PASS route_segment_mutation");
		end else begin
			$display("%0d errors, %0d results missing", errors, result_q.size());
			$display("FAIL route_segment_mutation");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/rsm_pkg.sv
hdl/rsm_if.sv
hdl/rsm_ctrl.sv
hdl/rsm_datapath.sv
hdl/route_segment_mutation.sv
test/tb_top.sv
